/* rtl/twcs_pkg.sv */
// Shared types and constants for the textured wall column span core.
// No dependencies; twcs_emit and the top-level core import this package.
package twcs_pkg;

  // Fixed field widths, sized for the largest screen and texture supported
  localparam int ROW_W   = 6;   // screen rows, up to 64
  localparam int TEX_W   = 7;   // texture coordinates, up to 128
  localparam int LH_W    = 15;  // line height, up to 64 * 256
  localparam int OFF_W   = 14;  // clipped half height offset
  localparam int STEP_W  = 24;  // texture step quotient, up to 128 << 16
  localparam int POS_W   = 32;  // Q16.16 texture position
  localparam int FRAC_W  = 21;  // hit point fraction bits
  localparam int DIST_W  = 16;

  // Wall face codes
  localparam logic [1:0] FACE_NORTH = 2'd0;
  localparam logic [1:0] FACE_SOUTH = 2'd1;
  localparam logic [1:0] FACE_EAST  = 2'd2;
  localparam logic [1:0] FACE_WEST  = 2'd3;

  typedef struct packed {
    logic [9:0]         column;
    logic [15:0]        wall_distance;
    logic               hit_side;
    logic signed [15:0] ray_dir_x;
    logic signed [15:0] ray_dir_y;
    logic [15:0]        player_x;
    logic [15:0]        player_y;
  } hit_item_t;

  typedef struct packed {
    logic [9:0]       out_column;
    logic [ROW_W-1:0] screen_row;
    logic [TEX_W-1:0] texel_x;
    logic [TEX_W-1:0] texel_y;
    logic [1:0]       wall_face;
    logic             last_row;
  } pixel_item_t;

  // Carried alongside the line height division
  typedef struct packed {
    logic [9:0]       column;
    logic [TEX_W-1:0] tx;
    logic [1:0]       face;
    logic             dist_zero;
  } tex_info_t;

  // Carried alongside the texture step division
  typedef struct packed {
    logic [9:0]       column;
    logic [TEX_W-1:0] tx;
    logic [1:0]       face;
    logic [ROW_W-1:0] first;
    logic [ROW_W-1:0] last;
    logic [OFF_W-1:0] off;
    logic             lh_zero;
  } clip_info_t;

  // One column span ready for row emission
  typedef struct packed {
    logic [9:0]       column;
    logic [TEX_W-1:0] tx;
    logic [1:0]       face;
    logic [ROW_W-1:0] first;
    logic [ROW_W-1:0] last;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] step;
  } span_t;

endpackage

/* rtl/twcs_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with a sideband.
// Depends on nothing; all stages advance together on en.
module twcs_div #(
  parameter int NW = 15,
  parameter int DW = 16,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [NW-1:0] quo,
  output logic [SW-1:0] out_side
);

  logic [NW-1:0] v;
  logic [DW-1:0] rem_r  [NW];
  logic [NW-1:0] quo_r  [NW];
  logic [NW-1:0] num_r  [NW];
  logic [DW-1:0] den_r  [NW];
  logic [SW-1:0] side_r [NW];

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic          pv;
    logic [DW-1:0] prem;
    logic [NW-1:0] pquo;
    logic [NW-1:0] pnum;
    logic [DW-1:0] pden;
    logic [SW-1:0] pside;
    logic [DW:0]   cat;
    logic [DW:0]   diff;
    logic          ge;

    // Select the previous stage, or the input for the first
    if (i == 0) begin : g_first
      assign pv    = in_valid;
      assign prem  = '0;
      assign pquo  = '0;
      assign pnum  = num;
      assign pden  = den;
      assign pside = in_side;
    end else begin : g_next
      assign pv    = v[i-1];
      assign prem  = rem_r[i-1];
      assign pquo  = quo_r[i-1];
      assign pnum  = num_r[i-1];
      assign pden  = den_r[i-1];
      assign pside = side_r[i-1];
    end

    // Trial subtract of the divisor from the shifted remainder
    assign cat  = {prem, pnum[NW-1]};
    assign diff = cat - {1'b0, pden};
    assign ge   = ~diff[DW];

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (en) begin
        v[i] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= ge ? diff[DW-1:0] : cat[DW-1:0];
        quo_r[i]  <= {pquo[NW-2:0], ge};
        num_r[i]  <= pnum << 1;
        den_r[i]  <= pden;
        side_r[i] <= pside;
      end
    end
  end

  assign out_valid = v[NW-1];
  assign quo       = quo_r[NW-1];
  assign out_side  = side_r[NW-1];

endmodule

/* rtl/twcs_emit.sv */
// Row emitter: walks one column span a row per cycle, while the output register is free, into that register.
// Depends on twcs_pkg.
module twcs_emit
  import twcs_pkg::*;
#(
  parameter int TEXTURE_SIZE = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        span_valid,
  output logic        span_ready,
  input  span_t       span,
  output logic        pix_valid,
  input  logic        pix_ready,
  output pixel_item_t pix
);

  localparam logic [TEX_W-1:0] TMASK = TEX_W'(TEXTURE_SIZE - 1);

  logic             busy;
  logic [ROW_W-1:0] row;
  logic [ROW_W-1:0] last;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] step;
  logic [9:0]       column;
  logic [TEX_W-1:0] tx;
  logic [1:0]       face;
  logic             slot_free;
  logic             load;
  logic             emit;
  logic             final_row;

  assign span_ready = ~busy;
  assign load       = span_valid & ~busy;
  assign slot_free  = ~pix_valid | pix_ready;
  assign emit       = busy & slot_free;
  assign final_row  = (row + ROW_W'(1)) == last;

  // Track the span in progress and the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pix_valid <= 1'b0;
    end else begin
      if (load) begin
        busy <= span.first < span.last;
      end else if (emit && final_row) begin
        busy <= 1'b0;
      end
      if (emit) begin
        pix_valid <= 1'b1;
      end else if (pix_ready) begin
        pix_valid <= 1'b0;
      end
    end
  end

  // Load a new span, or advance one row
  always_ff @(posedge clk) begin
    if (load) begin
      row    <= span.first;
      last   <= span.last;
      pos    <= span.pos;
      step   <= span.step;
      column <= span.column;
      tx     <= span.tx;
      face   <= span.face;
    end else if (emit) begin
      row <= row + ROW_W'(1);
      pos <= pos + step;
    end
    if (emit) begin
      pix.out_column <= column;
      pix.screen_row <= row;
      pix.texel_x    <= tx;
      pix.texel_y    <= pos[16 +: TEX_W] & TMASK;
      pix.wall_face  <= face;
      pix.last_row   <= final_row;
    end
  end

endmodule

/* rtl/textured_wall_column_span_core.sv */
// Textured wall column span core: one column hit in, one pixel item per drawn row out.
// Column accept to first row passes through two bit-per-stage dividers and the emitter.
// Throughput: one row per cycle while pix_ready allows; a span holds the input until its rows are out.
// The setup pipeline takes a column each cycle unless a finished span waits on a busy row emitter.
// Reset (rst, synchronous) clears all valid bits and the emitter; payload is not reset.
// Depends on twcs_pkg, twcs_div and twcs_emit.
module textured_wall_column_span_core
  import twcs_pkg::*;
#(
  parameter int SCREEN_HEIGHT = 64,
  parameter int TEXTURE_SIZE  = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        col_valid,
  output logic        col_ready,
  input  hit_item_t   col_hit,
  output logic        pix_valid,
  input  logic        pix_ready,
  output pixel_item_t pix
);

  localparam logic [LH_W-1:0]   LH_MAX   = LH_W'(SCREEN_HEIGHT * 256);
  localparam logic [STEP_W-1:0] STEP_NUM = STEP_W'(TEXTURE_SIZE * 65536);
  localparam logic [OFF_W-1:0]  HALF_SCR = OFF_W'(SCREEN_HEIGHT / 2);
  localparam logic [LH_W-1:0]   SCR_H    = LH_W'(SCREEN_HEIGHT);
  localparam logic [ROW_W-1:0]  ROW_MAX  = ROW_W'(SCREEN_HEIGHT - 1);
  localparam logic [TEX_W-1:0]  TEX_MAX  = TEX_W'(TEXTURE_SIZE - 1);
  localparam int TI_W = $bits(tex_info_t);
  localparam int CI_W = $bits(clip_info_t);

  logic adv;
  logic span_ready;

  // Stage 0: input register
  logic      s0_v;
  hit_item_t s0;

  // Stage 1: hit product and face
  logic              s1_v;
  logic [FRAC_W-1:0] s1_prod;
  logic [7:0]        s1_pfrac;
  logic              s1_mirror;
  logic [1:0]        s1_face;
  logic [9:0]        s1_column;
  logic [DIST_W-1:0] s1_dist;
  logic signed [15:0] ray_sel;
  logic signed [32:0] prod_full;
  logic              mirror_c;
  logic [1:0]        face_c;

  // Stage 2 logic feeding the line height divider
  logic [FRAC_W-1:0]   frac;
  logic [FRAC_W+7:0]   txp;
  logic [TEX_W-1:0]    tx_raw;
  tex_info_t           ti_in;

  // Line height divider output and clip stage
  logic            d1_v;
  logic [LH_W-1:0] d1_q;
  logic [TI_W-1:0] d1_side;
  tex_info_t       ti_out;
  logic [LH_W-1:0] lh;
  logic [OFF_W-1:0] half;
  logic [LH_W-1:0] bot;
  logic            s3_v;
  logic [LH_W-1:0] s3_lh;
  clip_info_t      s3;
  clip_info_t      ci_c;

  // Texture step divider output and span stages
  logic              d2_v;
  logic [STEP_W-1:0] d2_q;
  logic [CI_W-1:0]   d2_side;
  clip_info_t        ci_out;
  logic              s4_v;
  clip_info_t        s4;
  logic [POS_W-1:0]  s4_step;
  logic              s5_v;
  span_t             s5;
  logic [POS_W+OFF_W-1:0] pos_full;

  // Advance the whole setup pipeline when its tail can move on
  assign adv       = ~s5_v | span_ready;
  assign col_ready = adv;

  // Capture the column hit
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
    end else if (adv) begin
      s0_v <= col_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0 <= col_hit;
    end
  end

  // Pick the axis, mirror and face from the side and ray signs
  always_comb begin
    ray_sel   = s0.hit_side ? s0.ray_dir_x : s0.ray_dir_y;
    prod_full = $signed({1'b0, s0.wall_distance}) * ray_sel;
    if (s0.hit_side) begin
      mirror_c = s0.ray_dir_y[15];
      face_c   = (!s0.ray_dir_y[15] && s0.ray_dir_y != 16'sd0) ? FACE_NORTH : FACE_SOUTH;
    end else begin
      mirror_c = !s0.ray_dir_x[15] && s0.ray_dir_x != 16'sd0;
      face_c   = s0.ray_dir_x[15] ? FACE_EAST : FACE_WEST;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (adv) begin
      s1_v <= s0_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_prod   <= prod_full[FRAC_W-1:0];
      s1_pfrac  <= s0.hit_side ? s0.player_x[7:0] : s0.player_y[7:0];
      s1_mirror <= mirror_c;
      s1_face   <= face_c;
      s1_column <= s0.column;
      s1_dist   <= s0.wall_distance;
    end
  end

  // Form the hit fraction and the texture column
  always_comb begin
    frac   = s1_prod + {s1_pfrac, 13'd0};
    txp    = (FRAC_W + 8)'(frac) * (FRAC_W + 8)'(TEXTURE_SIZE);
    tx_raw = txp[FRAC_W +: TEX_W];
    ti_in.column    = s1_column;
    ti_in.tx        = s1_mirror ? (TEX_MAX - tx_raw) : tx_raw;
    ti_in.face      = s1_face;
    ti_in.dist_zero = s1_dist == '0;
  end

  twcs_div #(.NW(LH_W), .DW(DIST_W), .SW(TI_W)) u_div_lh (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s1_v),
    .num       (LH_MAX),
    .den       (s1_dist),
    .in_side   (ti_in),
    .out_valid (d1_v),
    .quo       (d1_q),
    .out_side  (d1_side)
  );

  // Clip the slice to the screen
  always_comb begin
    ti_out = tex_info_t'(d1_side);
    lh     = ti_out.dist_zero ? LH_MAX : d1_q;
    half   = lh[LH_W-1:1];
    bot    = {1'b0, half} + {1'b0, HALF_SCR};
    ci_c.column  = ti_out.column;
    ci_c.tx      = ti_out.tx;
    ci_c.face    = ti_out.face;
    ci_c.first   = (half >= HALF_SCR) ? '0 : ROW_W'(HALF_SCR - half);
    ci_c.last    = (bot >= SCR_H) ? ROW_MAX : bot[ROW_W-1:0];
    ci_c.off     = (half >= HALF_SCR) ? (half - HALF_SCR) : '0;
    ci_c.lh_zero = lh == '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (adv) begin
      s3_v <= d1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3    <= ci_c;
      s3_lh <= lh;
    end
  end

  twcs_div #(.NW(STEP_W), .DW(LH_W), .SW(CI_W)) u_div_step (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s3_v),
    .num       (STEP_NUM),
    .den       (s3_lh),
    .in_side   (s3),
    .out_valid (d2_v),
    .quo       (d2_q),
    .out_side  (d2_side)
  );

  assign ci_out = clip_info_t'(d2_side);

  // Hold the texture step
  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
      s5_v <= 1'b0;
    end else if (adv) begin
      s4_v <= d2_v;
      s5_v <= s4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4      <= ci_out;
      s4_step <= ci_out.lh_zero ? '0 : POS_W'(d2_q);
    end
  end

  // Start position is the clipped offset times the step
  assign pos_full = (POS_W + OFF_W)'(s4.off) * (POS_W + OFF_W)'(s4_step);

  always_ff @(posedge clk) begin
    if (adv) begin
      s5.column <= s4.column;
      s5.tx     <= s4.tx;
      s5.face   <= s4.face;
      s5.first  <= s4.first;
      s5.last   <= s4.last;
      s5.step   <= s4_step;
      s5.pos    <= pos_full[POS_W-1:0];
    end
  end

  twcs_emit #(.TEXTURE_SIZE(TEXTURE_SIZE)) u_emit (
    .clk        (clk),
    .rst        (rst),
    .span_valid (s5_v),
    .span_ready (span_ready),
    .span       (s5),
    .pix_valid  (pix_valid),
    .pix_ready  (pix_ready),
    .pix        (pix)
  );

  // A drawn row never reaches the bottom screen row
  a_row_range : assert property (@(posedge clk) disable iff (rst)
    pix_valid |-> pix.screen_row < ROW_MAX)
    else $error("row beyond span limit");

  // A span keeps emitting until its final row
  a_span_cont : assert property (@(posedge clk) disable iff (rst)
    pix_valid && pix_ready && !pix.last_row |=> pix_valid)
    else $error("span ended without final row");

  // Rows of one span stay on one column and count up
  a_span_col : assert property (@(posedge clk) disable iff (rst)
    pix_valid && pix_ready && !pix.last_row |=>
      pix.out_column == $past(pix.out_column) &&
      pix.screen_row == $past(pix.screen_row) + ROW_W'(1))
    else $error("span column or row order broken");

endmodule
